[design/olst_pkg.sv]
// olst_pkg: shared sizes, types and codes for the ordered list store.
// Used by olst_ram and ordered_list_store_core. No dependencies.
package olst_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    // compare width for positions against count, one bit of headroom
    localparam int PW         = ((CW > 7) ? CW : 7) + 1;

    typedef logic [AW-1:0]         t_addr;
    typedef logic [CW-1:0]         t_count;
    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_UPDATE_AT = 3'd4,
        CMD_DEL_FRONT = 3'd5,
        CMD_DEL_AT    = 3'd6,
        CMD_TRAVERSE  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_SCAN
    } t_state;

    // Sign-extend (or truncate) the 32-bit input word to storage width
    function automatic t_word to_word(input logic signed [31:0] v);
        to_word = DATA_WIDTH'(v);
    endfunction

    // Low 32 bits of a stored word, zero-extended when storage is narrower
    function automatic logic [31:0] to_item(input t_word w);
        to_item = 32'(w);
    endfunction

endpackage

[design/ordered_list_store_core.sv]
// ordered_list_store_core: bounded ordered list kept in one synchronous RAM.
// Depends on olst_pkg and olst_ram.
// Tail insert/delete, update and errors finish straight from idle; shifting insert/delete
//   moves the entries one place over first; search/traverse read one entry per cycle.
// One command at a time: start is taken only while not busy.
// Reset (i_rst_n low, synchronous) empties the list; results cannot be stalled.
module ordered_list_store_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_item,
    output logic [6:0]  o_length,
    output logic        o_last
);
    import olst_pkg::*;

    // control state
    t_state  r_state, n_state;
    t_count  r_count, n_count;
    logic    r_rvld, n_rvld;
    logic    r_rdone, n_rdone;
    logic    r_valid, n_valid;

    // walk and payload registers
    t_addr   r_ptr, n_ptr;
    t_addr   r_lim, n_lim;
    t_addr   r_wa, n_wa;
    t_word   r_word, n_word;
    logic    r_trav, n_trav;
    t_status r_status, n_status;
    logic    r_found, n_found;
    logic [31:0] r_item, n_item;
    logic [6:0]  r_len, n_len;
    logic    r_last, n_last;

    // RAM port
    logic  mem_we;
    t_addr mem_waddr;
    t_word mem_wdata;
    t_addr mem_raddr;
    t_word mem_rdata;

    olst_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // command decode helpers
    t_cmd          cmd;
    logic [PW-1:0] pos_e;
    logic [PW-1:0] cnt_e;
    logic          full;
    t_addr         pos_idx;
    t_addr         tail_idx;

    assign cmd      = t_cmd'(i_cmd);
    assign pos_e    = PW'(i_position);
    assign cnt_e    = PW'(r_count);
    assign full     = (r_count == CW'(DEPTH));
    assign pos_idx  = AW'(i_position - 7'd1);
    assign tail_idx = AW'(r_count - CW'(1));

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rvld  <= 1'b0;
            r_rdone <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rvld  <= n_rvld;
            r_rdone <= n_rdone;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_lim    <= n_lim;
        r_wa     <= n_wa;
        r_word   <= n_word;
        r_trav   <= n_trav;
        r_status <= n_status;
        r_found  <= n_found;
        r_item   <= n_item;
        r_len    <= n_len;
        r_last   <= n_last;
    end

    // next state, RAM control and result beat
    always_comb begin
        logic  do_ins;
        logic  do_del;
        logic  do_scan;
        logic  emit;
        t_addr idx;

        n_state  = r_state;
        n_count  = r_count;
        n_rvld   = r_rvld;
        n_rdone  = r_rdone;
        n_valid  = 1'b0;
        n_ptr    = r_ptr;
        n_lim    = r_lim;
        n_wa     = r_wa;
        n_word   = r_word;
        n_trav   = r_trav;
        n_status = r_status;
        n_found  = r_found;
        n_item   = r_item;
        n_len    = r_len;
        n_last   = r_last;

        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_wdata = mem_rdata;
        mem_raddr = r_ptr;

        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_scan = 1'b0;
        emit    = 1'b0;
        idx     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_word   = to_word(i_value);
                    n_status = STS_OK;
                    n_found  = 1'b0;
                    n_item   = '0;
                    n_last   = 1'b1;
                    case (cmd)
                        CMD_INS_FRONT: begin
                            if (full) begin
                                n_status = STS_FULL;
                                emit     = 1'b1;
                            end else begin
                                do_ins = 1'b1;
                                idx    = '0;
                            end
                        end
                        CMD_INS_BACK: begin
                            if (full) begin
                                n_status = STS_FULL;
                                emit     = 1'b1;
                            end else begin
                                do_ins = 1'b1;
                                idx    = AW'(r_count);
                            end
                        end
                        CMD_INS_AT: begin
                            if (pos_e == '0 || pos_e > cnt_e + PW'(1)) begin
                                n_status = STS_BADPOS;
                                emit     = 1'b1;
                            end else if (full) begin
                                n_status = STS_FULL;
                                emit     = 1'b1;
                            end else begin
                                do_ins = 1'b1;
                                idx    = pos_idx;
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count == '0) begin
                                emit = 1'b1;
                            end else begin
                                do_scan = 1'b1;
                            end
                        end
                        CMD_UPDATE_AT: begin
                            if (pos_e == '0 || pos_e > cnt_e) begin
                                n_status = STS_BADPOS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_idx;
                                mem_wdata = to_word(i_value);
                            end
                            emit = 1'b1;
                        end
                        CMD_DEL_FRONT: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                                emit     = 1'b1;
                            end else begin
                                do_del = 1'b1;
                                idx    = '0;
                            end
                        end
                        CMD_DEL_AT: begin
                            if (i_position == 7'd1 && r_count == '0) begin
                                n_status = STS_EMPTY;
                                emit     = 1'b1;
                            end else if (pos_e == '0 || pos_e > cnt_e) begin
                                n_status = STS_BADPOS;
                                emit     = 1'b1;
                            end else begin
                                do_del = 1'b1;
                                idx    = pos_idx;
                            end
                        end
                        CMD_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                                emit     = 1'b1;
                            end else begin
                                do_scan = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase

                    // insert: at the tail write at once, else shift up first
                    if (do_ins) begin
                        if (idx == AW'(r_count)) begin
                            mem_we    = 1'b1;
                            mem_waddr = idx;
                            mem_wdata = to_word(i_value);
                            n_count   = r_count + CW'(1);
                            emit      = 1'b1;
                        end else begin
                            n_state = S_INS;
                            n_ptr   = tail_idx;
                            n_lim   = idx;
                            n_rvld  = 1'b0;
                            n_rdone = 1'b0;
                        end
                    end

                    // delete: the tail entry just drops, else shift down
                    if (do_del) begin
                        if (idx == tail_idx) begin
                            n_count = r_count - CW'(1);
                            emit    = 1'b1;
                        end else begin
                            n_state = S_DEL;
                            n_ptr   = idx + AW'(1);
                            n_lim   = tail_idx;
                            n_rvld  = 1'b0;
                            n_rdone = 1'b0;
                        end
                    end

                    // search and traverse walk from the head
                    if (do_scan) begin
                        n_state = S_SCAN;
                        n_ptr   = '0;
                        n_lim   = tail_idx;
                        n_trav  = (cmd == CMD_TRAVERSE);
                        n_rvld  = 1'b0;
                        n_rdone = 1'b0;
                    end

                    if (emit) begin
                        n_valid = 1'b1;
                        n_len   = 7'(n_count);
                    end
                end
            end

            S_INS, S_DEL: begin
                // write back the word read last cycle, one place over
                if (r_rvld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wa;
                    mem_wdata = mem_rdata;
                end
                if (!r_rdone) begin
                    n_rvld = 1'b1;
                    n_wa   = (r_state == S_INS) ? r_ptr + AW'(1) : r_ptr - AW'(1);
                    if (r_ptr == r_lim) begin
                        n_rdone = 1'b1;
                    end else begin
                        n_ptr = (r_state == S_INS) ? r_ptr - AW'(1) : r_ptr + AW'(1);
                    end
                end else begin
                    n_rvld = 1'b0;
                    if (!r_rvld) begin
                        // shift finished: place the new word or shrink
                        if (r_state == S_INS) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_lim;
                            mem_wdata = r_word;
                            n_count   = r_count + CW'(1);
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_status = STS_OK;
                        n_found  = 1'b0;
                        n_item   = '0;
                        n_last   = 1'b1;
                        n_len    = 7'(n_count);
                    end
                end
            end

            S_SCAN: begin
                // issue reads in order; r_wa tracks the index in flight
                if (!r_rdone) begin
                    n_rvld = 1'b1;
                    n_wa   = r_ptr;
                    if (r_ptr == r_lim) begin
                        n_rdone = 1'b1;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end else begin
                    n_rvld = 1'b0;
                end

                if (r_rvld) begin
                    n_status = STS_OK;
                    n_len    = 7'(r_count);
                    if (r_trav) begin
                        n_valid = 1'b1;
                        n_found = 1'b0;
                        n_item  = to_item(mem_rdata);
                        n_last  = (r_wa == r_lim);
                        if (r_wa == r_lim) begin
                            n_state = S_IDLE;
                        end
                    end else if (mem_rdata == r_word || r_wa == r_lim) begin
                        n_valid = 1'b1;
                        n_found = (mem_rdata == r_word);
                        n_item  = '0;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_found  = r_found;
    assign o_item   = r_item;
    assign o_length = r_len;
    assign o_last   = r_last;

endmodule

[design/olst_ram.sv]
// olst_ram: entry storage, one write port and one read port, registered read.
// Depends on olst_pkg for address and word types.
module olst_ram (
    input  logic           i_clk,
    input  logic           i_we,
    input  olst_pkg::t_addr i_waddr,
    input  olst_pkg::t_word i_wdata,
    input  olst_pkg::t_addr i_raddr,
    output olst_pkg::t_word o_rdata
);
    import olst_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
